// ----- design/plb_pkg.sv -----
// Shared types, mode codes and fixed-point helpers for the pixel layer blender.
package plb_pkg;

    typedef logic [15:0] fix_t;

    localparam fix_t FIX_ONE     = 16'h8000;
    localparam fix_t FIX_ONE_INC = 16'h8001;

    localparam logic [3:0] MODE_NORMAL   = 4'd0;
    localparam logic [3:0] MODE_BEHIND   = 4'd1;
    localparam logic [3:0] MODE_ERASE    = 4'd2;
    localparam logic [3:0] MODE_REPLACE  = 4'd3;
    localparam logic [3:0] MODE_MULTIPLY = 4'd4;
    localparam logic [3:0] MODE_DIVIDE   = 4'd5;
    localparam logic [3:0] MODE_BURN     = 4'd6;
    localparam logic [3:0] MODE_DODGE    = 4'd7;
    localparam logic [3:0] MODE_DARKEN   = 4'd8;
    localparam logic [3:0] MODE_LIGHTEN  = 4'd9;
    localparam logic [3:0] MODE_SUBTRACT = 4'd10;
    localparam logic [3:0] MODE_ADD      = 4'd11;
    localparam logic [3:0] MODE_RECOLOR  = 4'd12;

    typedef struct packed {
        fix_t [2:0] dst_c;
        fix_t [2:0] src_c;
        fix_t       dst_a;
        fix_t       src_a;
        fix_t       opac;
        logic [3:0] mode;
        logic       run_end;
    } pix_t;

    typedef struct packed {
        fix_t [2:0] color;
        fix_t       alpha;
        logic       run_end;
    } res_t;

    function automatic fix_t sat_in(input fix_t x);
        return (x > FIX_ONE) ? FIX_ONE : x;
    endfunction

    function automatic fix_t sat17(input logic [16:0] x);
        return (x > {1'b0, FIX_ONE}) ? FIX_ONE : x[15:0];
    endfunction

    // Operands never exceed one, so the product fits in 31 bits.
    function automatic fix_t fmul(input fix_t a, input fix_t b);
        logic [31:0] p;
        p = a * b;
        return p[30:15];
    endfunction

endpackage

// ----- design/plb_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module plb_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 16,
    parameter int Q_W   = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             ovf,
    output logic [Q_W-1:0]   quo
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = HI_W + DEN_W;

    logic [DEN_W-1:0] rem_reg  [0:Q_W-1];
    logic [DEN_W-1:0] rem_next [0:Q_W-1];
    logic [DEN_W-1:0] den_reg  [0:Q_W-1];
    logic [DEN_W-1:0] den_next [0:Q_W-1];
    logic [Q_W-1:0]   low_reg  [0:Q_W-1];
    logic [Q_W-1:0]   low_next [0:Q_W-1];
    logic [Q_W-1:0]   quo_reg  [0:Q_W];
    logic [Q_W-1:0]   quo_next [0:Q_W];
    logic             ovf_reg  [0:Q_W];
    logic             ovf_next [0:Q_W];

    always_comb
    begin
        logic [HI_W-1:0]  hi;
        logic [DEN_W:0]   trial;
        logic             qbit;
        hi = num[NUM_W-1:Q_W];
        // The quotient overflows when the top part already reaches the divisor.
        ovf_next[0] = CMP_W'(hi) >= CMP_W'(den);
        rem_next[0] = DEN_W'(hi);
        den_next[0] = den;
        low_next[0] = num[Q_W-1:0];
        quo_next[0] = '0;
        for (int k = 1; k <= Q_W; k++)
        begin
            trial = {rem_reg[k-1], low_reg[k-1][Q_W-1]};
            qbit  = trial >= {1'b0, den_reg[k-1]};
            quo_next[k] = {quo_reg[k-1][Q_W-2:0], qbit};
            ovf_next[k] = ovf_reg[k-1];
            if (k < Q_W)
            begin
                rem_next[k] = qbit ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : DEN_W'(trial);
                den_next[k] = den_reg[k-1];
                low_next[k] = {low_reg[k-1][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                low_reg[k] <= low_next[k];
            end
            for (int k = 0; k <= Q_W; k++)
            begin
                quo_reg[k] <= quo_next[k];
                ovf_reg[k] <= ovf_next[k];
            end
        end
    end

    assign ovf = ovf_reg[Q_W];
    assign quo = quo_reg[Q_W];

endmodule

// ----- design/plb_delay.sv -----
// Stallable delay line that carries a valid bit alongside its data.
module plb_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  logic [WIDTH-1:0] data,
    output logic             valid_dly,
    output logic [WIDTH-1:0] data_dly
);

    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] dat_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dat_reg[0] <= data;
            for (int k = 1; k < DEPTH; k++)
            begin
                dat_reg[k] <= dat_reg[k-1];
            end
        end
    end

    assign valid_dly = vld_reg[DEPTH-1];
    assign data_dly  = dat_reg[DEPTH-1];

endmodule

// ----- design/plb_pd.sv -----
// Three-stage datapath for the normal, behind, erase and replace modes.
module plb_pd
    import plb_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  pix_t       pix,
    input  fix_t       sa,
    output fix_t [2:0] color,
    output fix_t       alpha
);

    pix_t       p1_reg;
    fix_t       tn1_reg;
    fix_t       tb1_reg;
    fix_t       tn1_next;
    fix_t       tb1_next;

    fix_t [2:0] x2_reg, x2_next;
    fix_t [2:0] y2_reg, y2_next;
    fix_t       xa2_reg, xa2_next;
    fix_t       ya2_reg, ya2_next;
    fix_t [2:0] cb2_reg;
    fix_t       ab2_reg;
    logic [3:0] mode2_reg;

    fix_t [2:0] col3_reg, col3_next;
    fix_t       alp3_reg, alp3_next;

    always_comb
    begin
        tn1_next = FIX_ONE - sa;
        tb1_next = fmul(FIX_ONE - pix.dst_a, sa);
    end

    always_comb
    begin
        fix_t tsel;
        tsel = (p1_reg.mode == MODE_BEHIND) ? tb1_reg : p1_reg.opac;
        for (int i = 0; i < 3; i++)
        begin
            x2_next[i] = fmul(p1_reg.dst_c[i], tn1_reg);
            y2_next[i] = fmul(p1_reg.src_c[i], tsel);
        end
        xa2_next = fmul(p1_reg.dst_a, tn1_reg);
        ya2_next = fmul(p1_reg.src_a, tsel);
    end

    always_comb
    begin
        col3_next = cb2_reg;
        alp3_next = ab2_reg;
        case (mode2_reg)
            MODE_NORMAL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    col3_next[i] = sat17({1'b0, x2_reg[i]} + {1'b0, y2_reg[i]});
                end
                alp3_next = sat17({1'b0, xa2_reg} + {1'b0, ya2_reg});
            end
            MODE_BEHIND:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    col3_next[i] = sat17({1'b0, cb2_reg[i]} + {1'b0, y2_reg[i]});
                end
                alp3_next = sat17({1'b0, ab2_reg} + {1'b0, ya2_reg});
            end
            MODE_ERASE:
            begin
                col3_next = x2_reg;
                alp3_next = xa2_reg;
            end
            MODE_REPLACE:
            begin
                col3_next = y2_reg;
                alp3_next = ya2_reg;
            end
            default:
            begin
                // Separable and unknown modes keep the destination here.
                col3_next = cb2_reg;
                alp3_next = ab2_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= pix;
            tn1_reg   <= tn1_next;
            tb1_reg   <= tb1_next;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            xa2_reg   <= xa2_next;
            ya2_reg   <= ya2_next;
            cb2_reg   <= p1_reg.dst_c;
            ab2_reg   <= p1_reg.dst_a;
            mode2_reg <= p1_reg.mode;
            col3_reg  <= col3_next;
            alp3_reg  <= alp3_next;
        end
    end

    assign color = col3_reg;
    assign alpha = alp3_reg;

endmodule

// ----- design/plb_mix.sv -----
// Three-stage mix of the separable mode result and premultiply by destination alpha.
module plb_mix
    import plb_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  fix_t [2:0] ub,
    input  fix_t [2:0] comp,
    input  fix_t       sa,
    input  fix_t       dst_a,
    output fix_t [2:0] color
);

    logic [31:0] p1_reg  [0:2];
    logic [31:0] p1_next [0:2];
    logic [31:0] p2_reg  [0:2];
    logic [31:0] p2_next [0:2];
    fix_t        ab1_reg;
    fix_t [2:0]  mix2_reg, mix2_next;
    fix_t        ab2_reg;
    fix_t [2:0]  col3_reg, col3_next;

    always_comb
    begin
        fix_t sa1;
        sa1 = FIX_ONE - sa;
        for (int i = 0; i < 3; i++)
        begin
            p1_next[i] = sa1 * ub[i];
            p2_next[i] = sa * comp[i];
        end
    end

    always_comb
    begin
        logic [32:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            sum = {1'b0, p1_reg[i]} + {1'b0, p2_reg[i]};
            mix2_next[i] = (sum[32:15] > 18'(FIX_ONE)) ? FIX_ONE : sum[30:15];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (ab2_reg == FIX_ONE)
            begin
                col3_next[i] = mix2_reg[i];
            end
            else if (ab2_reg == '0)
            begin
                col3_next[i] = '0;
            end
            else
            begin
                col3_next[i] = fmul(mix2_reg[i], ab2_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= p1_next[i];
                p2_reg[i] <= p2_next[i];
            end
            ab1_reg  <= dst_a;
            mix2_reg <= mix2_next;
            ab2_reg  <= ab1_reg;
            col3_reg <= col3_next;
        end
    end

    assign color = col3_reg;

endmodule

// ----- design/pixel_layer_blend_top.sv -----
// Top level of the premultiplied pixel layer blender.
// The blender takes one pixel beat per cycle while pix_stall is low and returns
// one result beat per pixel. Two 17-stage pipelined dividers in series make up
// most of the pipeline: the first unpremultiplies source and destination color,
// the second performs the divide, burn and dodge mode divisions. Every mode goes
// through the same pipeline, so results leave in order. An output register plus
// one skid entry let the block keep accepting pixels while a finished result
// waits; pix_stall rises only once both are full. Opacity and blend mode live at
// byte addresses 0 and 4 of the register port and should be written while idle.
module pixel_layer_blend_top
    import plb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic [15:0] dst_blue,
    input  logic [15:0] dst_green,
    input  logic [15:0] dst_red,
    input  logic [15:0] dst_alpha,
    input  logic [15:0] src_blue,
    input  logic [15:0] src_green,
    input  logic [15:0] src_red,
    input  logic [15:0] src_alpha,
    input  logic        run_end,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [15:0] res_blue,
    output logic [15:0] res_green,
    output logic [15:0] res_red,
    output logic [15:0] res_alpha,
    output logic        run_end_out
);

    localparam logic REG_OPACITY = 1'b0;
    localparam logic REG_MODE    = 1'b1;

    localparam int PIX_W = $bits(pix_t);
    localparam int A_W   = PIX_W + 16;
    localparam int B_W   = PIX_W + 16 + 96;

    // Register port
    fix_t       opacity_reg;
    logic [3:0] mode_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= FIX_ONE;
            mode_reg    <= MODE_NORMAL;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_OPACITY: opacity_reg <= pwdata[15:0];
                REG_MODE:    mode_reg    <= pwdata[3:0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_MODE) ? {28'd0, mode_reg} : {16'd0, opacity_reg};

    // Pipeline advance: frozen only while the skid entry holds a result.
    logic en;
    logic skid_v_reg;
    assign en        = !skid_v_reg;
    assign pix_stall = skid_v_reg;

    function automatic fix_t unpremul_fin(input fix_t c, input fix_t a,
                                          input logic ovf, input fix_t q);
        fix_t r;
        if (a == FIX_ONE)
        begin
            r = c;
        end
        else if (a == '0)
        begin
            r = '0;
        end
        else if (ovf || q > FIX_ONE)
        begin
            r = FIX_ONE;
        end
        else
        begin
            r = q;
        end
        return r;
    endfunction

    // Stage 1: input saturation
    pix_t pix1_reg, pix1_next;
    logic v1_reg;

    always_comb
    begin
        pix1_next.dst_c   = {sat_in(dst_red), sat_in(dst_green), sat_in(dst_blue)};
        pix1_next.src_c   = {sat_in(src_red), sat_in(src_green), sat_in(src_blue)};
        pix1_next.dst_a   = sat_in(dst_alpha);
        pix1_next.src_a   = sat_in(src_alpha);
        pix1_next.opac    = sat_in(opacity_reg);
        pix1_next.mode    = mode_reg;
        pix1_next.run_end = run_end;
    end

    // Stage 2: source alpha times opacity
    pix_t pix2_reg;
    fix_t sa2_reg;
    logic v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pix_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix1_reg <= pix1_next;
            pix2_reg <= pix1_reg;
            sa2_reg  <= fmul(pix1_reg.src_a, pix1_reg.opac);
        end
    end

    // Unpremultiply dividers: lanes 0..2 destination, 3..5 source.
    logic       up_ovf [0:5];
    fix_t       up_quo [0:5];

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_unpremul
        plb_div #(.NUM_W(31), .DEN_W(16), .Q_W(16)) u_div_dst (
            .clk (clk),
            .en  (en),
            .num ({pix1_reg.dst_c[ch], 15'd0}),
            .den (pix1_reg.dst_a),
            .ovf (up_ovf[ch]),
            .quo (up_quo[ch])
        );
        plb_div #(.NUM_W(31), .DEN_W(16), .Q_W(16)) u_div_src (
            .clk (clk),
            .en  (en),
            .num ({pix1_reg.src_c[ch], 15'd0}),
            .den (pix1_reg.src_a),
            .ovf (up_ovf[ch+3]),
            .quo (up_quo[ch+3])
        );
    end

    logic           v18;
    logic [A_W-1:0] a18;
    pix_t           pix18;
    fix_t           sa18;

    plb_delay #(.WIDTH(A_W), .DEPTH(16)) u_dly_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (v2_reg),
        .data      ({pix2_reg, sa2_reg}),
        .valid_dly (v18),
        .data_dly  (a18)
    );

    assign pix18 = pix_t'(a18[A_W-1:16]);
    assign sa18  = a18[15:0];

    // Stage 19: unpremultiplied colors
    pix_t       pix19_reg;
    fix_t       sa19_reg;
    fix_t [2:0] ub19_reg, ub19_next;
    fix_t [2:0] us19_reg, us19_next;
    logic       v19_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ub19_next[i] = unpremul_fin(pix18.dst_c[i], pix18.dst_a, up_ovf[i], up_quo[i]);
            us19_next[i] = unpremul_fin(pix18.src_c[i], pix18.src_a, up_ovf[i+3],
                                        up_quo[i+3]);
        end
    end

    // Mode division operands and the non-dividing mode results.
    logic [30:0] cd_num [0:2];
    fix_t        cd_den [0:2];
    fix_t [2:0]  simp20_next;

    always_comb
    begin
        fix_t        a;
        fix_t        b;
        fix_t        na;
        logic [30:0] a_inc;
        logic [30:0] na_inc;
        for (int i = 0; i < 3; i++)
        begin
            a      = ub19_reg[i];
            b      = us19_reg[i];
            na     = FIX_ONE - a;
            a_inc  = 31'({a, 15'd0}) + 31'(a);
            na_inc = 31'({na, 15'd0}) + 31'(na);
            case (pix19_reg.mode)
                MODE_DIVIDE:
                begin
                    cd_num[i] = a_inc + 31'(b[15:1]);
                    cd_den[i] = b + 16'd1;
                end
                MODE_BURN:
                begin
                    cd_num[i] = na_inc;
                    cd_den[i] = b + 16'd1;
                end
                MODE_DODGE:
                begin
                    cd_num[i] = a_inc;
                    cd_den[i] = FIX_ONE_INC - b;
                end
                default:
                begin
                    cd_num[i] = '0;
                    cd_den[i] = 16'd1;
                end
            endcase
            case (pix19_reg.mode)
                MODE_MULTIPLY: simp20_next[i] = fmul(a, b);
                MODE_DARKEN:   simp20_next[i] = (a < b) ? a : b;
                MODE_LIGHTEN:  simp20_next[i] = (a > b) ? a : b;
                MODE_SUBTRACT: simp20_next[i] = (b < a) ? a - b : '0;
                MODE_ADD:      simp20_next[i] = sat17({1'b0, a} + {1'b0, b});
                default:       simp20_next[i] = b;
            endcase
        end
    end

    logic cd_ovf [0:2];
    fix_t cd_quo [0:2];

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_modediv
        plb_div #(.NUM_W(31), .DEN_W(16), .Q_W(16)) u_div_mode (
            .clk (clk),
            .en  (en),
            .num (cd_num[ch]),
            .den (cd_den[ch]),
            .ovf (cd_ovf[ch]),
            .quo (cd_quo[ch])
        );
    end

    // Stage 20
    pix_t       pix20_reg;
    fix_t       sa20_reg;
    fix_t [2:0] ub20_reg;
    fix_t [2:0] simp20_reg;
    logic       v20_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v19_reg <= 1'b0;
            v20_reg <= 1'b0;
        end
        else if (en)
        begin
            v19_reg <= v18;
            v20_reg <= v19_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix19_reg  <= pix18;
            sa19_reg   <= sa18;
            ub19_reg   <= ub19_next;
            us19_reg   <= us19_next;
            pix20_reg  <= pix19_reg;
            sa20_reg   <= sa19_reg;
            ub20_reg   <= ub19_reg;
            simp20_reg <= simp20_next;
        end
    end

    logic           v36;
    logic [B_W-1:0] b36;
    pix_t           pix36;
    fix_t           sa36;
    fix_t [2:0]     ub36;
    fix_t [2:0]     simp36;

    plb_delay #(.WIDTH(B_W), .DEPTH(16)) u_dly_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (v20_reg),
        .data      ({pix20_reg, sa20_reg, ub20_reg, simp20_reg}),
        .valid_dly (v36),
        .data_dly  (b36)
    );

    assign pix36  = pix_t'(b36[B_W-1:112]);
    assign sa36   = b36[111:96];
    assign ub36   = b36[95:48];
    assign simp36 = b36[47:0];

    // Stage 37: final per-channel mode result
    pix_t       pix37_reg;
    fix_t       sa37_reg;
    fix_t [2:0] ub37_reg;
    fix_t [2:0] comp37_reg, comp37_next;
    logic       v37_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (pix36.mode)
                MODE_DIVIDE, MODE_DODGE:
                    comp37_next[i] = (cd_ovf[i] || cd_quo[i] > FIX_ONE) ? FIX_ONE : cd_quo[i];
                MODE_BURN:
                    comp37_next[i] = (cd_ovf[i] || cd_quo[i] > FIX_ONE) ? '0 :
                                     FIX_ONE - cd_quo[i];
                default:
                    comp37_next[i] = simp36[i];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v37_reg <= 1'b0;
        end
        else if (en)
        begin
            v37_reg <= v36;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix37_reg  <= pix36;
            sa37_reg   <= sa36;
            ub37_reg   <= ub36;
            comp37_reg <= comp37_next;
        end
    end

    // Stages 38 to 40: both datapaths in parallel
    fix_t [2:0] pd_color;
    fix_t       pd_alpha;
    fix_t [2:0] mix_color;

    plb_pd u_pd (
        .clk   (clk),
        .en    (en),
        .pix   (pix37_reg),
        .sa    (sa37_reg),
        .color (pd_color),
        .alpha (pd_alpha)
    );

    plb_mix u_mix (
        .clk   (clk),
        .en    (en),
        .ub    (ub37_reg),
        .comp  (comp37_reg),
        .sa    (sa37_reg),
        .dst_a (pix37_reg.dst_a),
        .color (mix_color)
    );

    logic       v40;
    logic [4:0] c40;
    logic [3:0] mode40;

    plb_delay #(.WIDTH(5), .DEPTH(3)) u_dly_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (v37_reg),
        .data      ({pix37_reg.mode, pix37_reg.run_end}),
        .valid_dly (v40),
        .data_dly  (c40)
    );

    assign mode40 = c40[4:1];

    res_t p_res;

    always_comb
    begin
        p_res.color   = (mode40 inside {[MODE_MULTIPLY:MODE_RECOLOR]}) ? mix_color : pd_color;
        p_res.alpha   = pd_alpha;
        p_res.run_end = c40[0];
    end

    // Output register and skid entry
    logic out_v_reg, out_v_next;
    res_t out_d_reg, out_d_next;
    logic skid_v_next;
    res_t skid_d_reg, skid_d_next;
    logic take;

    assign take = out_v_reg && !res_stall;

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (skid_v_reg)
        begin
            if (take)
            begin
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
        end
        else
        begin
            if (take)
            begin
                out_v_next = 1'b0;
            end
            if (v40)
            begin
                if (!out_v_reg || take)
                begin
                    out_v_next = 1'b1;
                    out_d_next = p_res;
                end
                else
                begin
                    skid_v_next = 1'b1;
                    skid_d_next = p_res;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign res_valid   = out_v_reg;
    assign res_blue    = out_d_reg.color[0];
    assign res_green   = out_d_reg.color[1];
    assign res_red     = out_d_reg.color[2];
    assign res_alpha   = out_d_reg.alpha;
    assign run_end_out = out_d_reg.run_end;

endmodule

// ----- design/plb_checker.sv -----
// Port-level checker for the pixel layer blender and its bind statement.
module plb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pix_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [15:0] res_blue,
    input logic [15:0] res_green,
    input logic [15:0] res_red,
    input logic [15:0] res_alpha
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result beat dropped while stalled");

    // Every result channel is saturated at one.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_blue <= 16'h8000 && res_green <= 16'h8000 &&
                       res_red <= 16'h8000 && res_alpha <= 16'h8000))
        else $error("result channel above one");

    // Input back-pressure only starts after the output side held a stalled beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_stall) |-> $past(res_valid && res_stall))
        else $error("input stalled without output back-pressure");

    // An opacity write reads back in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2] |=>
            (paddr[2] || prdata == {16'd0, $past(pwdata[15:0])}))
        else $error("opacity readback mismatch");

endmodule

bind pixel_layer_blend_top plb_checker u_plb_checker (.*);

// ----- verif/pixel_layer_blend_top_tb.sv -----
// Self-checking testbench for the premultiplied pixel layer blender.
`timescale 1ns / 1ps

module pixel_layer_blend_top_tb;
    import plb_pkg::*;

    localparam logic [2:0] ADDR_OPACITY = 3'd0;
    localparam logic [2:0] ADDR_MODE    = 3'd4;
    localparam logic [3:0] MODE_UNKNOWN_FIRST = 4'd13;
    localparam logic [3:0] MODE_UNKNOWN_LAST  = 4'd15;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 445;

    typedef struct {
        logic [15:0] dst [4];   // blue, green, red, alpha
        logic [15:0] src [4];
        logic        run_end;
    } pixel_t;

    typedef struct {
        logic [15:0] chan [4];  // blue, green, red, alpha
        logic        run_end;
    } blended_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        pix_valid, pix_stall;
    logic [15:0] dst_blue, dst_green, dst_red, dst_alpha;
    logic [15:0] src_blue, src_green, src_red, src_alpha;
    logic        run_end;
    logic        res_valid, res_stall;
    logic [15:0] res_blue, res_green, res_red, res_alpha;
    logic        run_end_out;

    logic [15:0] opacity_shadow;
    logic [3:0]  mode_shadow;
    blended_t    pending_pixels [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatch_count;
    int          pixels_sent;
    int          results_seen;

    pixel_layer_blend_top dut (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Fixed-point helpers of the blend arithmetic, all carried in 64 bits.
    function automatic logic [63:0] clip_one(input logic [63:0] x);
        return (x > 64'd32768) ? 64'd32768 : x;
    endfunction

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 15;
    endfunction

    function automatic logic [63:0] to_straight(input logic [63:0] c, input logic [63:0] a);
        if (a == 64'd32768)
            return c;
        if (a == 0)
            return 0;
        return clip_one((c * 64'd32768) / a);
    endfunction

    function automatic logic [63:0] to_premul(input logic [63:0] c, input logic [63:0] a);
        if (a == 64'd32768)
            return c;
        if (a == 0)
            return 0;
        return clip_one((c * a) / 64'd32768);
    endfunction

    function automatic logic [63:0] channel_mode(input logic [3:0] mode,
                                                 input logic [63:0] a,
                                                 input logic [63:0] b);
        longint t;
        case (mode)
            MODE_MULTIPLY: return fx_mul(a, b);
            MODE_DIVIDE:   return clip_one((a * 64'd32769 + b / 2) / (b + 1));
            MODE_BURN:
            begin
                t = 64'sd32768 - longint'(((64'd32768 - a) * 64'd32769) / (b + 1));
                return (t < 0) ? 64'd0 : clip_one(64'(t));
            end
            MODE_DODGE:    return clip_one((a * 64'd32769) / (64'd32769 - b));
            MODE_DARKEN:   return (a < b) ? a : b;
            MODE_LIGHTEN:  return (a > b) ? a : b;
            MODE_SUBTRACT: return (b < a) ? a - b : 64'd0;
            MODE_ADD:      return clip_one(a + b);
            default:       return b;
        endcase
    endfunction

    function automatic blended_t blend_pixel(input pixel_t p, input logic [15:0] opac_reg,
                                             input logic [3:0] mode);
        blended_t    r;
        logic [63:0] d [4];
        logic [63:0] s [4];
        logic [63:0] o, t, sa, sa1, ub, us, mix;
        for (int i = 0; i < 4; i++)
        begin
            d[i] = clip_one(64'(p.dst[i]));
            s[i] = clip_one(64'(p.src[i]));
        end
        o = clip_one(64'(opac_reg));
        case (mode)
            MODE_NORMAL:
            begin
                t = 64'd32768 - fx_mul(s[3], o);
                for (int i = 0; i < 4; i++)
                    r.chan[i] = 16'(clip_one(fx_mul(d[i], t) + fx_mul(s[i], o)));
            end
            MODE_BEHIND:
            begin
                t = fx_mul(64'd32768 - d[3], fx_mul(s[3], o));
                for (int i = 0; i < 4; i++)
                    r.chan[i] = 16'(clip_one(d[i] + fx_mul(s[i], t)));
            end
            MODE_ERASE:
            begin
                t = 64'd32768 - fx_mul(s[3], o);
                for (int i = 0; i < 4; i++)
                    r.chan[i] = 16'(fx_mul(d[i], t));
            end
            MODE_REPLACE:
                for (int i = 0; i < 4; i++)
                    r.chan[i] = 16'(fx_mul(s[i], o));
            MODE_MULTIPLY, MODE_DIVIDE, MODE_BURN, MODE_DODGE, MODE_DARKEN,
            MODE_LIGHTEN, MODE_SUBTRACT, MODE_ADD, MODE_RECOLOR:
            begin
                sa  = fx_mul(s[3], o);
                sa1 = 64'd32768 - sa;
                for (int i = 0; i < 3; i++)
                begin
                    ub  = to_straight(d[i], d[3]);
                    us  = to_straight(s[i], s[3]);
                    mix = clip_one((sa1 * ub + sa * channel_mode(mode, ub, us)) >> 15);
                    r.chan[i] = 16'(to_premul(mix, d[3]));
                end
                r.chan[3] = 16'(d[3]);
            end
            default:
                for (int i = 0; i < 4; i++)
                    r.chan[i] = 16'(d[i]);
        endcase
        r.run_end = p.run_end;
        return r;
    endfunction

    // Channel values weighted toward the interesting points zero, near zero, one and above one.
    function automatic logic [15:0] pick_channel();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom);
            3: return 16'($urandom_range(32769, 65535));
            4: return 16'($urandom_range(0, 64));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p.dst[3] = pick_channel();
        p.src[3] = pick_channel();
        for (int i = 0; i < 3; i++)
        begin
            // Mostly well-formed premultiplied color, sometimes color above alpha.
            if ($urandom_range(9) < 8)
            begin
                p.dst[i] = 16'($urandom_range(0, (p.dst[3] > 16'd32768) ? 32768 : p.dst[3]));
                p.src[i] = 16'($urandom_range(0, (p.src[3] > 16'd32768) ? 32768 : p.src[3]));
            end
            else
            begin
                p.dst[i] = pick_channel();
                p.src[i] = pick_channel();
            end
        end
        p.run_end = 1'($urandom);
        return p;
    endfunction

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_OPACITY)
            opacity_shadow = data[15:0];
        else
            mode_shadow = data[3:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        pix_valid <= 1'b0;
    endtask

    task automatic set_blend(input logic [15:0] opac, input logic [3:0] mode);
        // The last pixel must not stay offered while the registers change.
        stop_sending();
        wait_drained();
        reg_write(ADDR_OPACITY, 32'(opac));
        reg_write(ADDR_MODE, 32'(mode));
    endtask

    task automatic send_pixel(input pixel_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        dst_blue  <= p.dst[0];
        dst_green <= p.dst[1];
        dst_red   <= p.dst[2];
        dst_alpha <= p.dst[3];
        src_blue  <= p.src[0];
        src_green <= p.src[1];
        src_red   <= p.src[2];
        src_alpha <= p.src[3];
        run_end   <= p.run_end;
        pix_valid <= 1'b1;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        pending_pixels.push_back(blend_pixel(p, opacity_shadow, mode_shadow));
        pixels_sent++;
    endtask

    function automatic logic [15:0] pick_opacity();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic test_directed();
        pixel_t p;
        int     k;
        k = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int m = MODE_NORMAL; m <= MODE_UNKNOWN_LAST; m++)
        begin
            set_blend(16'd32768, 4'(m));
            // Rotate through extremes: zero under one, one under zero, above one, color over alpha.
            for (int i = 0; i < 4; i++)
            begin
                case (k % 4)
                    0: begin p.dst[i] = 16'd0;     p.src[i] = 16'd32768; end
                    1: begin p.dst[i] = 16'd32768; p.src[i] = 16'd0;     end
                    2: begin p.dst[i] = 16'hFFFF;  p.src[i] = 16'hFFFF;  end
                    default: begin p.dst[i] = 16'd20000; p.src[i] = 16'd9000; end
                endcase
            end
            if (k % 4 == 3)
            begin
                p.dst[3] = 16'd5000;
                p.src[3] = 16'd3000;
            end
            p.run_end = 1'(k);
            send_pixel(p);
            k++;
        end
        stop_sending();
        set_blend(16'd0, MODE_NORMAL);
        send_pixel(random_pixel());
        set_blend(16'hFFFF, MODE_BURN);
        send_pixel(random_pixel());
        set_blend(16'hFFFF, MODE_DODGE);
        send_pixel(random_pixel());
        stop_sending();
    endtask

    task automatic test_random(input int src_pct, input int dst_pct);
        logic [3:0] mode;
        send_idle_pct = src_pct;
        recv_idle_pct = dst_pct;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            if (n % 75 == 0)
            begin
                stop_sending();
                mode = ($urandom_range(15) == 0) ?
                       4'($urandom_range(MODE_UNKNOWN_FIRST, MODE_UNKNOWN_LAST)) :
                       4'($urandom_range(MODE_NORMAL, MODE_RECOLOR));
                set_blend(pick_opacity(), mode);
            end
            if (n == RANDOM_PER_PHASE / 2)
            begin
                // Let the pipeline run completely dry before the next pixel.
                stop_sending();
                while (pending_pixels.size() != 0)
                    @(posedge clk);
            end
            send_pixel(random_pixel());
        end
        stop_sending();
    endtask

    always @(negedge clk)
        res_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        blended_t    want;
        logic [15:0] got [4];
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            got = '{res_blue, res_green, res_red, res_alpha};
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat b=%0d g=%0d r=%0d a=%0d",
                             got[0], got[1], got[2], got[3]);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got != want.chan || run_end_out !== want.run_end)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: want b=%0d g=%0d r=%0d a=%0d e=%0b, ",
                                  "got b=%0d g=%0d r=%0d a=%0d e=%0b"},
                                 results_seen, want.chan[0], want.chan[1], want.chan[2],
                                 want.chan[3], want.run_end, got[0], got[1], got[2],
                                 got[3], run_end_out);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("pixel_layer_blend_top: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_OPACITY;
        pwdata = '0;
        pix_valid = 1'b0;
        {dst_blue, dst_green, dst_red, dst_alpha} = '0;
        {src_blue, src_green, src_red, src_alpha} = '0;
        run_end = 1'b0;
        opacity_shadow = 16'd32768;
        mode_shadow = MODE_NORMAL;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mismatch_count = 0;
        pixels_sent = 0;
        results_seen = 0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(21, 69);
        test_random(69, 21);
        test_random(0, 0);

        wait_drained();
        if (pending_pixels.size() != 0)
            mismatch_count++;
        $display("Blended %0d pixels across all sixteen mode codes and opacity extremes,",
                 pixels_sent);
        $display("with %0d result beats checked under source and sink throttling.",
                 results_seen);
        if (mismatch_count == 0)
            $display("pixel_layer_blend_top: match");
        else
            $display("pixel_layer_blend_top: mismatch");
        $finish;
    end

endmodule
